>>> rtl/rita_pkg.sv
// Shared types and constants of the run/idle time accounting block.
// Holds the entry layouts, status codes and controller states.
// Depends on nothing; the top level and the bench import it.
package rita_pkg;

  localparam int unsigned OP_COUNT   = 64;
  localparam int unsigned RING_DEPTH = 4096;

  localparam int unsigned OP_W     = 6;
  localparam int unsigned TS_W     = 32;
  localparam int unsigned SLOT_W   = 12;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned OP_AW   = $clog2(OP_COUNT);
  localparam int unsigned RING_AW = $clog2(RING_DEPTH);

  localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);
  localparam logic [OP_W:0]      OP_LIMIT  = (OP_W + 1)'(OP_COUNT);

  typedef enum logic [STATUS_W-1:0] {
    STAT_RECORDED = 2'd0,
    STAT_FIRST    = 2'd1,
    STAT_REJECTED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_VISIT
  } fsm_e;

  // One ring entry: point that owns it and its accumulated ticks.
  typedef struct packed {
    logic [OP_W-1:0] point;
    logic [TS_W-1:0] idle;
    logic [TS_W-1:0] run;
  } ring_entry_t;

  // Per-point totals, one memory word per operating point.
  typedef struct packed {
    logic [TS_W-1:0] visits;
    logic [TS_W-1:0] idle;
    logic [TS_W-1:0] run;
  } totals_t;

  // Input tdata layout, lowest field last.
  typedef struct packed {
    logic            pad;
    logic [TS_W-1:0] timestamp;
    logic            cpu_idle;
    logic [OP_W-1:0] op_index;
  } in_data_t;

  // Output tdata layout, lowest field last.
  typedef struct packed {
    logic [3:0]        pad;
    logic [TS_W-1:0]   visit_count;
    logic [TS_W-1:0]   total_idle;
    logic [TS_W-1:0]   total_run;
    logic              idle_overflowed;
    logic              run_overflowed;
    logic [TS_W-1:0]   entry_idle;
    logic [TS_W-1:0]   entry_run;
    logic [TS_W-1:0]   elapsed;
    logic [OP_W-1:0]   entry_point;
    logic [SLOT_W-1:0] slot_index;
  } out_data_t;

  localparam int unsigned IN_DATA_W  = $bits(in_data_t);
  localparam int unsigned OUT_DATA_W = $bits(out_data_t);

endpackage

>>> rtl/rita_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds until the next read enable. No dependencies.
module rita_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/run_idle_time_accounting.sv
// Top level of the run/idle time accounting block.
// Depends on rita_pkg and on rita_ram for the ring and the per-point totals.
//
// Each sample transaction (op_index, cpu_idle, timestamp in tdata, mode in tuser)
// charges the ticks since the previous sample to the current ring entry and to
// the run or idle total of the sampled operating point, and returns one result
// transaction (status in tuser). A sample reads the ring entry and the point's
// totals from their memories first, then updates and writes them back. When the
// point changes a visit state follows: the visit count of the point left behind
// lives in the same totals memory, which has one read port, so it is read while
// updating and written in the visit state. The result sits in an output register,
// so the next sample is taken while a result waits; a new result is held back
// only while the previous one is still not taken. Reset and restart need no
// clearing pass: the totals carry one valid bit per point that reset and restart
// clear at once, and the ring is only ever read at the current entry, which is
// always written before it is read, except just after reset, covered by one flag.
module run_idle_time_accounting (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: op_index[5:0], cpu_idle[6], timestamp[38:7], zero pad[39]
  input  logic [rita_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: mode (0 sample, 1 restart capture)
  input  logic                            s_axis_tuser,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: slot_index[11:0], entry_point[17:12], elapsed[49:18],
  //        entry_run[81:50], entry_idle[113:82], run_overflowed[114],
  //        idle_overflowed[115], total_run[147:116], total_idle[179:148],
  //        visit_count[211:180], zero pad[215:212]
  output logic [rita_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: status
  output logic [rita_pkg::STATUS_W-1:0]   m_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready
);

  import rita_pkg::*;

  // Controller state and captured sample.
  fsm_e state_q, state_d;

  in_data_t        in_data;
  logic            mode_q;
  logic [OP_W-1:0] op_q;
  logic            idle_q;
  logic [TS_W-1:0] ts_q;
  logic [TS_W-1:0] dt_q, dt_d;

  // Architectural state kept in flops.
  logic [TS_W-1:0]     last_time_q, last_time_d;
  logic                started_q, started_d;
  logic [RING_AW-1:0]  slot_q, slot_d;
  logic                ring_valid_q, ring_valid_d;
  logic [OP_COUNT-1:0] tot_valid_q, tot_valid_d;
  logic [OP_AW-1:0]    vis_addr_q, vis_addr_d;

  // Output register.
  logic      out_valid_q, out_valid_d;
  out_data_t out_data_q, out_data_d;
  status_e   out_status_q, out_status_d;

  // Memory ports.
  logic               ring_we, ring_re;
  logic [RING_AW-1:0] ring_waddr;
  ring_entry_t        ring_wdata, ring_rdata;
  logic               tot_we, tot_re;
  logic [OP_AW-1:0]   tot_waddr, tot_raddr;
  totals_t            tot_wdata, tot_rdata;

  // Handshake and sequencing strobes.
  logic accept;
  logic out_free;
  logic exec_fire;

  // Update datapath.
  logic               op_ok;
  logic [OP_AW-1:0]   op_addr;
  logic [OP_AW-1:0]   cur_addr;
  ring_entry_t        cur_entry;
  totals_t            tot_op;
  totals_t            tot_cur;
  logic               recording;
  logic               change;
  logic [RING_AW-1:0] slot_next;
  logic [RING_AW-1:0] slot_new;
  logic [TS_W-1:0]    add_run, add_idle;
  logic [TS_W:0]      sum_run, sum_idle;
  logic [TS_W-1:0]    new_run, new_idle;
  logic               run_ovf, idle_ovf;
  logic [TS_W-1:0]    new_tot_run, new_tot_idle;
  logic [RING_AW-1:0]        out_slot;
  logic [RING_AW+SLOT_W-1:0] slot_ext;

  assign in_data = in_data_t'(s_axis_tdata);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign exec_fire = (state_q == FSM_EXEC) && out_free;

  // Elapsed ticks, worked out at capture; a backward step loses one tick.
  assign dt_d = in_data.timestamp - last_time_q -
                TS_W'(in_data.timestamp < last_time_q);

  // --------------------------------------------------------------------
  // Controller: next state
  // --------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (exec_fire) begin
          state_d = (recording && change) ? FSM_VISIT : FSM_IDLE;
        end
      end
      FSM_VISIT: begin
        state_d = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------
  // Controller: outputs (memory strobes, input ready)
  // --------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    ring_re       = 1'b0;
    ring_we       = 1'b0;
    tot_re        = 1'b0;
    tot_we        = 1'b0;
    tot_raddr     = in_data.op_index[OP_AW-1:0];
    tot_waddr     = op_addr;
    tot_wdata     = '{visits: tot_op.visits, idle: new_tot_idle, run: new_tot_run};
    unique case (state_q)
      FSM_IDLE: begin
        // Fetch the current ring entry and the sampled point's totals.
        s_axis_tready = 1'b1;
        ring_re       = s_axis_tvalid;
        tot_re        = s_axis_tvalid;
      end
      FSM_EXEC: begin
        if (exec_fire) begin
          ring_we   = mode_q || recording;
          tot_we    = recording;
          // Fetch the totals of the point being left.
          tot_re    = recording && change;
          tot_raddr = cur_addr;
        end
      end
      FSM_VISIT: begin
        tot_we    = 1'b1;
        tot_waddr = vis_addr_q;
        tot_wdata = '{visits: tot_cur.visits + TS_W'(1), idle: tot_cur.idle,
                      run: tot_cur.run};
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------
  // Update datapath
  // --------------------------------------------------------------------
  assign op_ok    = {1'b0, op_q} < OP_LIMIT;
  assign op_addr  = op_q[OP_AW-1:0];
  // The entry read before any write after reset belongs to point 0, no ticks.
  assign cur_entry = ring_valid_q ? ring_rdata : '0;
  assign cur_addr  = cur_entry.point[OP_AW-1:0];
  assign tot_op    = tot_valid_q[op_addr] ? tot_rdata : '0;
  assign tot_cur   = tot_valid_q[vis_addr_q] ? tot_rdata : '0;

  assign recording = !mode_q && op_ok && started_q;
  assign change    = cur_entry.point != op_q;
  assign slot_next = (slot_q == RING_LAST) ? '0 : slot_q + RING_AW'(1);
  assign slot_new  = (recording && change) ? slot_next : slot_q;

  // A fresh entry starts from zero ticks.
  assign add_run  = idle_q ? '0 : dt_q;
  assign add_idle = idle_q ? dt_q : '0;
  assign sum_run  = {1'b0, (change ? '0 : cur_entry.run)} + {1'b0, add_run};
  assign sum_idle = {1'b0, (change ? '0 : cur_entry.idle)} + {1'b0, add_idle};
  assign new_run  = sum_run[TS_W-1:0];
  assign new_idle = sum_idle[TS_W-1:0];
  assign run_ovf  = sum_run[TS_W];
  assign idle_ovf = sum_idle[TS_W];

  assign new_tot_run  = tot_op.run + add_run;
  assign new_tot_idle = tot_op.idle + add_idle;

  // Restart opens entry 0 for the sampled point (point 0 if rejected).
  always_comb begin
    if (mode_q) begin
      ring_waddr = '0;
      ring_wdata = '{point: (op_ok ? op_q : '0), idle: '0, run: '0};
    end else begin
      ring_waddr = slot_new;
      ring_wdata = '{point: op_q, idle: new_idle, run: new_run};
    end
  end

  // --------------------------------------------------------------------
  // Result assembly
  // --------------------------------------------------------------------
  assign out_slot = mode_q ? '0 : slot_new;
  assign slot_ext = {{SLOT_W{1'b0}}, out_slot};

  always_comb begin
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    if (exec_fire) begin
      out_data_d            = '0;
      out_data_d.slot_index = slot_ext[SLOT_W-1:0];
      if (mode_q) begin
        out_status_d           = op_ok ? STAT_FIRST : STAT_REJECTED;
        out_data_d.entry_point = op_ok ? op_q : '0;
      end else if (!op_ok) begin
        out_status_d           = STAT_REJECTED;
        out_data_d.entry_point = cur_entry.point;
        out_data_d.entry_run   = cur_entry.run;
        out_data_d.entry_idle  = cur_entry.idle;
      end else if (!started_q) begin
        out_status_d           = STAT_FIRST;
        out_data_d.entry_point = cur_entry.point;
        out_data_d.entry_run   = cur_entry.run;
        out_data_d.entry_idle  = cur_entry.idle;
        out_data_d.total_run   = tot_op.run;
        out_data_d.total_idle  = tot_op.idle;
        out_data_d.visit_count = tot_op.visits;
      end else begin
        out_status_d               = STAT_RECORDED;
        out_data_d.entry_point     = op_q;
        out_data_d.elapsed         = dt_q;
        out_data_d.entry_run       = new_run;
        out_data_d.entry_idle      = new_idle;
        out_data_d.run_overflowed  = run_ovf;
        out_data_d.idle_overflowed = idle_ovf;
        out_data_d.total_run       = new_tot_run;
        out_data_d.total_idle      = new_tot_idle;
        out_data_d.visit_count     = tot_op.visits;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------
  // State update
  // --------------------------------------------------------------------
  always_comb begin
    last_time_d  = last_time_q;
    started_d    = started_q;
    slot_d       = slot_q;
    ring_valid_d = ring_valid_q;
    tot_valid_d  = tot_valid_q;
    vis_addr_d   = vis_addr_q;
    if (exec_fire) begin
      if (mode_q) begin
        // Restart: rewind the ring, drop all totals.
        slot_d       = '0;
        started_d    = op_ok;
        ring_valid_d = 1'b1;
        tot_valid_d  = '0;
        if (op_ok) begin
          last_time_d = ts_q;
        end
      end else if (op_ok) begin
        last_time_d = ts_q;
        started_d   = 1'b1;
        if (started_q) begin
          slot_d               = slot_new;
          ring_valid_d         = 1'b1;
          tot_valid_d[op_addr] = 1'b1;
          vis_addr_d           = cur_addr;
        end
      end
    end
    if (state_q == FSM_VISIT) begin
      tot_valid_d[vis_addr_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FSM_IDLE;
      last_time_q  <= '0;
      started_q    <= 1'b0;
      slot_q       <= '0;
      ring_valid_q <= 1'b0;
      tot_valid_q  <= '0;
      vis_addr_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_time_q  <= last_time_d;
      started_q    <= started_d;
      slot_q       <= slot_d;
      ring_valid_q <= ring_valid_d;
      tot_valid_q  <= tot_valid_d;
      vis_addr_q   <= vis_addr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Captured sample and result payload carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= s_axis_tuser;
      op_q   <= in_data.op_index;
      idle_q <= in_data.cpu_idle;
      ts_q   <= in_data.timestamp;
      dt_q   <= dt_d;
    end
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_data_q);
  assign m_axis_tuser  = out_status_q;

  // --------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------
  rita_ram #(
    .WIDTH ($bits(ring_entry_t)),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (slot_q),
    .rdata_o (ring_rdata)
  );

  rita_ram #(
    .WIDTH ($bits(totals_t)),
    .DEPTH (OP_COUNT)
  ) u_totals_ram (
    .clk_i   (clk_i),
    .we_i    (tot_we),
    .waddr_i (tot_waddr),
    .wdata_i (tot_wdata),
    .re_i    (tot_re),
    .raddr_i (tot_raddr),
    .rdata_o (tot_rdata)
  );

  // --------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------
  a_visit_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_VISIT |-> $past(state_q) == FSM_EXEC)
    else $error("visit update without a preceding update cycle");

  a_no_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ring_we || tot_we) |-> state_q != FSM_IDLE)
    else $error("memory write while no sample is in progress");

  a_visit_other_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_VISIT |-> vis_addr_q != op_addr)
    else $error("visit counted for the point just sampled");

  a_restart_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && mode_q |=> slot_q == '0 && tot_valid_q == '0)
    else $error("restart left ring position or totals behind");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_data_q))
    else $error("pending result changed before it was taken");

endmodule

>>> bench/run_idle_time_accounting_tb.sv
// Self-checking bench for run_idle_time_accounting: streams samples through the block
// and compares every result transaction with an in-bench accounting predictor.
// Depends on rita_pkg and the block's RTL only.
`timescale 1ns / 100ps

module run_idle_time_accounting_tb;
  import rita_pkg::*;

  localparam int unsigned RANDOM_SAMPLES = 340;
  // Short full-rate burst that opens a new ring entry on every sample.
  localparam int unsigned WRAP_SAMPLES   = 40;
  localparam int unsigned MAX_WAIT       = 19;
  // Worst quiet stretch is a sender gap plus a receiver stall plus the block's own work.
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned REPORT_LIMIT   = 10;

  // One sample as the stimulus sees it, with its handshake pacing attached.
  typedef struct {
    logic            mode;
    logic [OP_W-1:0] op;
    logic            idle;
    logic [TS_W-1:0] ts;
    int unsigned     gap;    // idle cycles of the sender before this sample
    int unsigned     stall;  // cycles tready stays low after its result
    bit              drain;  // hold this sample until every result is in
  } sample_t;

  // Predicted result transaction.
  typedef struct {
    status_e     status;
    out_data_t   data;
    int unsigned stall;
  } report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;

  run_idle_time_accounting dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sample_t     sample_queue[$];
  report_t     pending_reports[$];
  int unsigned mismatch_count = 0;
  int unsigned next_stall     = 0;

  // ---------------------------------------------------------------------------
  // Accounting predictor: its own copy of the ring and the per-point totals.
  // Only run/idle ticks and the owning point of a ring entry reach the result,
  // so the opening timestamp and the stored overflow flags are not kept.
  // ---------------------------------------------------------------------------
  logic [TS_W-1:0]    acct_last;
  bit                 acct_started;
  logic [RING_AW-1:0] acct_slot;
  logic [TS_W-1:0]    ring_run   [RING_DEPTH];
  logic [TS_W-1:0]    ring_idle  [RING_DEPTH];
  logic [OP_W-1:0]    ring_point [RING_DEPTH];
  logic [TS_W-1:0]    sum_run    [OP_COUNT];
  logic [TS_W-1:0]    sum_idle   [OP_COUNT];
  logic [TS_W-1:0]    sum_visits [OP_COUNT];

  // Empty the ring and the totals; entry 0 falls back to point 0.
  function automatic void clear_accounts();
    acct_slot = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_run[i]   = '0;
      ring_idle[i]  = '0;
      ring_point[i] = '0;
    end
    for (int p = 0; p < OP_COUNT; p++) begin
      sum_run[p]    = '0;
      sum_idle[p]   = '0;
      sum_visits[p] = '0;
    end
  endfunction

  function automatic report_t account_sample(sample_t smp);
    report_t         rep;
    logic [TS_W-1:0] dt;
    logic [TS_W:0]   acc;
    logic [OP_W-1:0] cur;
    bit              ok;
    rep.data   = '0;
    rep.status = STAT_RECORDED;
    rep.stall  = smp.stall;
    ok = int'(smp.op) < OP_COUNT;

    // Restart capture wipes everything before the sample itself is handled.
    if (smp.mode) begin
      clear_accounts();
      acct_started = 1'b0;
      if (ok) ring_point[0] = smp.op;
    end

    if (!ok) begin
      rep.status = STAT_REJECTED;
    end else begin
      // A timestamp that went backwards is taken as one pass of the counter.
      dt = (smp.ts >= acct_last) ? smp.ts - acct_last : 32'hFFFF_FFFF - acct_last + smp.ts;
      acct_last = smp.ts;
      if (!acct_started) begin
        acct_started = 1'b1;
        rep.status = STAT_FIRST;
      end else begin
        cur = ring_point[acct_slot];
        // Point change: count a visit for the point left and open a new entry.
        if (smp.op != cur) begin
          if (int'(cur) < OP_COUNT) sum_visits[cur]++;
          acct_slot = (acct_slot == RING_LAST) ? '0 : acct_slot + 1'b1;
          ring_run[acct_slot]   = '0;
          ring_idle[acct_slot]  = '0;
          ring_point[acct_slot] = smp.op;
        end
        if (smp.idle) begin
          acc = {1'b0, ring_idle[acct_slot]} + dt;
          rep.data.idle_overflowed = acc[TS_W];
          ring_idle[acct_slot] = acc[TS_W-1:0];
          sum_idle[smp.op] += dt;
        end else begin
          acc = {1'b0, ring_run[acct_slot]} + dt;
          rep.data.run_overflowed = acc[TS_W];
          ring_run[acct_slot] = acc[TS_W-1:0];
          sum_run[smp.op] += dt;
        end
        rep.data.elapsed = dt;
      end
    end

    rep.data.slot_index  = SLOT_W'(acct_slot);
    rep.data.entry_point = ring_point[acct_slot];
    rep.data.entry_run   = ring_run[acct_slot];
    rep.data.entry_idle  = ring_idle[acct_slot];
    if (ok) begin
      rep.data.total_run   = sum_run[smp.op];
      rep.data.total_idle  = sum_idle[smp.op];
      rep.data.visit_count = sum_visits[smp.op];
    end
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: present queued samples, honor each one's gap and drain request,
  // and predict the result of every sample at the edge that accepts it.
  // ---------------------------------------------------------------------------
  sample_t     on_bus;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : sample_driver
    in_data_t word;
    bit       taken;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      gap_left = 0;
    end else begin
      taken = s_axis_tvalid && s_axis_tready;
      if (taken) begin
        pending_reports.push_back(account_sample(on_bus));
        gap_left = (sample_queue.size() != 0) ? sample_queue[0].gap : 0;
      end
      // Only pick the next sample once the bus is free; a single NBA per step.
      if (!s_axis_tvalid || taken) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_queue.size() != 0 &&
                     !(sample_queue[0].drain && pending_reports.size() != 0)) begin
          on_bus = sample_queue.pop_front();
          word = '0;
          word.op_index  = on_bus.op;
          word.cpu_idle  = on_bus.idle;
          word.timestamp = on_bus.ts;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= word;
          s_axis_tuser  <= on_bus.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: drop tready for the stall that came with the last result taken.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : result_ready
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) stall_left = next_stall;
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic [TS_W-1:0] want, logic [TS_W-1:0] got);
    if (got !== want)
      note_mismatch($sformatf("%s mismatch: expected %h, got %h", name, want, got));
  endtask

  // Check results at the negedge before the edge that takes them: outputs and
  // tready are stable here, and the sender only touches the queue at posedge.
  always @(negedge clk_i) begin : result_check
    report_t   want;
    out_data_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_reports.size() == 0) begin
        next_stall = 0;
        note_mismatch("result transaction with no sample waiting for it");
      end else begin
        want = pending_reports.pop_front();
        next_stall = want.stall;
        compare_field("status",          32'(want.status),               32'(m_axis_tuser));
        compare_field("slot_index",      32'(want.data.slot_index),      32'(got.slot_index));
        compare_field("entry_point",     32'(want.data.entry_point),     32'(got.entry_point));
        compare_field("elapsed",         want.data.elapsed,              got.elapsed);
        compare_field("entry_run",       want.data.entry_run,            got.entry_run);
        compare_field("entry_idle",      want.data.entry_idle,           got.entry_idle);
        compare_field("run_overflowed",  32'(want.data.run_overflowed),  32'(got.run_overflowed));
        compare_field("idle_overflowed", 32'(want.data.idle_overflowed), 32'(got.idle_overflowed));
        compare_field("total_run",       want.data.total_run,            got.total_run);
        compare_field("total_idle",      want.data.total_idle,           got.total_idle);
        compare_field("visit_count",     want.data.visit_count,          got.visit_count);
      end
    end
  end

  // Watchdog: a stretch with no transaction on either side means a hang.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin : hang_watch
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_sample(logic mode, logic [OP_W-1:0] op, logic idle, logic [TS_W-1:0] ts,
                             int unsigned gap, int unsigned stall, bit drain);
    sample_t smp;
    smp.mode  = mode;
    smp.op    = op;
    smp.idle  = idle;
    smp.ts    = ts;
    smp.gap   = gap;
    smp.stall = stall;
    smp.drain = drain;
    sample_queue.push_back(smp);
  endtask

  function automatic int unsigned draw_wait();
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: a directed opening, a point-change burst, then a random stretch.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [OP_W-1:0] op_now;
    logic [OP_W-1:0] hot_ops[4];
    logic [TS_W-1:0] ts_now;
    logic            mode;
    bit              quiet;
    int unsigned     pick;

    acct_last    = '0;
    acct_started = 1'b0;
    clear_accounts();

    // First sample after reset is only stored; the next one leaves point 0.
    push_sample(1'b0, 6'd5,  1'b0, 32'd100,       draw_wait(), draw_wait(), 1'b0);
    push_sample(1'b0, 6'd5,  1'b0, 32'd300,       draw_wait(), draw_wait(), 1'b0);
    push_sample(1'b0, 6'd5,  1'b1, 32'd1000,      draw_wait(), draw_wait(), 1'b0);
    // Highest point with huge steps: run time wraps on a backwards timestamp.
    push_sample(1'b0, 6'd63, 1'b0, 32'hFFFF_FFF0, draw_wait(), draw_wait(), 1'b0);
    push_sample(1'b0, 6'd63, 1'b0, 32'hFFFF_FFF8, draw_wait(), draw_wait(), 1'b0);
    push_sample(1'b0, 6'd63, 1'b0, 32'h8000_0000, draw_wait(), draw_wait(), 1'b0);
    // Idle side: near-full step, zero step, then an idle wrap.
    push_sample(1'b0, 6'd63, 1'b1, 32'h7FFF_FFFF, draw_wait(), draw_wait(), 1'b0);
    push_sample(1'b0, 6'd63, 1'b1, 32'h7FFF_FFFF, draw_wait(), draw_wait(), 1'b0);
    push_sample(1'b0, 6'd63, 1'b1, 32'hFFFF_FFFF, draw_wait(), draw_wait(), 1'b0);
    // Backwards from all ones to zero gives zero elapsed.
    push_sample(1'b0, 6'd0,  1'b1, 32'h0000_0000, draw_wait(), draw_wait(), 1'b0);
    // Restart after a full drain, then back-to-back restarts.
    push_sample(1'b1, 6'd42, 1'b0, 32'h1234_5678, draw_wait(), draw_wait(), 1'b1);
    push_sample(1'b0, 6'd42, 1'b0, 32'h1234_5679, draw_wait(), draw_wait(), 1'b0);
    push_sample(1'b0, 6'd0,  1'b0, 32'hFFFF_FFFF, draw_wait(), draw_wait(), 1'b0);
    push_sample(1'b1, 6'd0,  1'b0, 32'hFFFF_FFFF, 0,           0,           1'b0);
    push_sample(1'b1, 6'd63, 1'b1, 32'h0000_0000, 0,           0,           1'b0);
    push_sample(1'b0, 6'd63, 1'b1, 32'hAAAA_AAAA, draw_wait(), draw_wait(), 1'b0);
    push_sample(1'b0, 6'd21, 1'b0, 32'h5555_5555, draw_wait(), draw_wait(), 1'b0);
    push_sample(1'b0, 6'd42, 1'b1, 32'hFFFF_FFFE, draw_wait(), draw_wait(), 1'b0);

    // Point-change burst: restart, then change point on every sample at full rate.
    ts_now = $urandom();
    op_now = OP_W'($urandom_range(0, OP_COUNT - 1));
    push_sample(1'b1, op_now, 1'b0, ts_now, 0, 0, 1'b1);
    for (int n = 0; n < WRAP_SAMPLES; n++) begin
      op_now = op_now + OP_W'($urandom_range(1, OP_COUNT - 1));
      ts_now = ts_now + $urandom_range(1, 500);
      // Sprinkle a few waits so the burst is not perfectly uniform.
      pick = $urandom_range(0, 99);
      push_sample(1'b0, op_now, 1'($urandom_range(0, 1)), ts_now,
                  (pick < 3) ? draw_wait() : 0, (pick > 96) ? draw_wait() : 0, 1'b0);
    end

    // Random stretch: mostly dwelling on a few points, with restarts,
    // big jumps, backwards timestamps and arbitrary values mixed in.
    for (int h = 0; h < 4; h++) hot_ops[h] = OP_W'($urandom_range(0, OP_COUNT - 1));
    quiet = 1'b0;
    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      if (n % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
      mode = ($urandom_range(0, 99) < 3);
      pick = $urandom_range(0, 99);
      if (pick >= 80) op_now = OP_W'($urandom_range(0, OP_COUNT - 1));
      else if (pick >= 55) op_now = hot_ops[$urandom_range(0, 3)];
      pick = $urandom_range(0, 99);
      if (pick < 65) ts_now = ts_now + $urandom_range(0, 2000);
      else if (pick < 75) ts_now = ts_now + $urandom_range(32'h4000_0000, 32'hFFFF_FFFF);
      else if (pick < 88) ts_now = $urandom();
      else if (pick < 94) ts_now = ts_now - $urandom_range(1, 100);
      push_sample(mode, op_now, 1'($urandom_range(0, 1)), ts_now,
                  quiet ? 0 : draw_wait(), quiet ? 0 : draw_wait(),
                  $urandom_range(0, 49) == 0);
    end

    // Hold reset, then release it at a clock edge.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every sample to go out and every result to come back.
    do @(negedge clk_i);
    while (sample_queue.size() != 0 || s_axis_tvalid || pending_reports.size() != 0);
    // Give a stray extra result the chance to show up.
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
